// ===== hdl/brf_pkg.sv =====
// package: shared types and constants for the bitmap range fill block
`default_nettype none
package brf_pkg;
   localparam int WordBits = 8;
   localparam logic [1:0] ModeFree = 2'd0;
   localparam logic [1:0] ModeMove = 2'd1;
   localparam logic [1:0] ModeQuery = 2'd2;
   localparam logic [1:0] ModeNop = 2'd3;

   // controller to datapath commands
   typedef struct packed {
      logic load;     // capture item fields and clipped ranges
      logic wr;       // write back current word and step to the next
      logic first;    // start of a pass: reset walk counters
      logic dst_pass; // walk destination range instead of source
   } cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic src_ok;
      logic dst_ok;
      logic last_word;
   } sts_type;
endpackage
`default_nettype wire

// ===== hdl/bitmap_range_fill_and_free_run.sv =====
// file: top level of the bitmap range fill and free run block
// Occupancy bitmap of slots 1..slots_in_use, all occupied after reset.
// req_ channel: one operation item (mode, source and destination range).
//   mode 0 frees the source range, mode 1 moves occupancy count from the
//   source into the lowest free slots of the destination, mode 2 queries
//   the longest free run in the source range and is the only mode with a
//   result on the rsp_ channel.
// csr_ channel: write of slots_in_use; csr_ready is low while an item is
//   in work.
// The range is walked one 8-bit word at a time, each word through the
// states READ (read address), WAIT (ram read latency) and WRITE
// (write-back). Mode 1 adds a destination pass after the source pass.
// After DONE the controller returns to idle, where the next item can be
// taken.
// One item is worked at a time; req_stall is high while busy.
// A result waits in the output register while rsp_stall is high, and no
// new item is taken until it leaves.
// Synchronous reset marks every slot occupied at once through per-word
// flags, with no clearing pass, and sets slots_in_use to 1024.
`default_nettype none
module bitmap_range_fill_and_free_run import brf_pkg::*; #(
   parameter int SLOTS = 1024
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output      logic        req_stall,
   input  wire logic [1:0]  req_mode,
   input  wire logic [10:0] req_src_low,
   input  wire logic [10:0] req_src_high,
   input  wire logic [10:0] req_dst_low,
   input  wire logic [10:0] req_dst_high,
   output      logic        rsp_valid,
   input  wire logic        rsp_stall,
   output      logic [10:0] rsp_longest_free_run,
   input  wire logic        csr_valid,
   output      logic        csr_ready,
   input  wire logic [10:0] csr_slots_in_use
);
   cmd_type cmd;
   sts_type sts;
   logic busy;
   logic [10:0] slots_ff;

   // configuration register, written only between items
   assign csr_ready = !busy;
   always_ff @(posedge clock) begin
      if (reset) begin
         slots_ff <= 11'd1024;
      end else if (csr_valid && csr_ready) begin
         slots_ff <= csr_slots_in_use;
      end
   end

   brf_ctrl u_ctrl (
      .clock(clock), .reset(reset), .req_valid(req_valid),
      .req_stall(req_stall), .req_mode(req_mode), .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall), .busy(busy), .cmd(cmd), .sts(sts)
   );

   brf_datapath #(.SLOTS(SLOTS)) u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .sts(sts), .mode(req_mode),
      .src_low(req_src_low), .src_high(req_src_high),
      .dst_low(req_dst_low), .dst_high(req_dst_high),
      .slots_in_use(slots_ff), .longest_free_run(rsp_longest_free_run)
   );
endmodule
`default_nettype wire

// ===== hdl/brf_ram.sv =====
// file: generic ram with one write port and one registered read port
`default_nettype none
module brf_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output      logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end
endmodule
`default_nettype wire

// ===== hdl/brf_datapath.sv =====
// file: datapath walking the bitmap one word at a time
`default_nettype none
module brf_datapath import brf_pkg::*; #(
   parameter int SLOTS = 1024
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire cmd_type     cmd,
   output      sts_type     sts,
   input  wire logic [1:0]  mode,
   input  wire logic [10:0] src_low,
   input  wire logic [10:0] src_high,
   input  wire logic [10:0] dst_low,
   input  wire logic [10:0] dst_high,
   input  wire logic [10:0] slots_in_use,
   output      logic [10:0] longest_free_run
);
   localparam int NWords = (SLOTS + WordBits - 1) / WordBits;
   localparam int AW = (NWords > 1) ? $clog2(NWords) : 1;
   localparam int SW = $clog2(NWords * WordBits + 1);
   localparam int CW = SW + 1;

   logic [1:0]    mode_ff;
   logic [SW-1:0] sl_ff, sh_ff, dl_ff, dh_ff;
   logic          src_ok_ff, dst_ok_ff;
   logic [AW-1:0] addr_ff, addr_in;
   logic [AW-1:0] end_ff;
   logic [SW-1:0] count_ff, count_in;
   logic [SW-1:0] run_ff, run_in, best_ff, best_in;
   logic [WordBits-1:0] rdata, wdata;
   logic          valid_ff;
   logic [AW-1:0] valid_addr_ff;
   // one bit per word: zero means the word never written, reads as all ones
   logic [NWords-1:0] init_ff;

   // clip logic
   logic [CW-1:0] n_c, sl_c, sh_c, dl_c, dh_c;
   always_comb begin
      n_c = (CW'(slots_in_use) > CW'(SLOTS)) ? CW'(SLOTS) : CW'(slots_in_use);
      sl_c = (src_low == 11'd0) ? CW'(1) : CW'(src_low);
      sh_c = (CW'(src_high) > n_c) ? n_c : CW'(src_high);
      dl_c = (dst_low == 11'd0) ? CW'(1) : CW'(dst_low);
      dh_c = (CW'(dst_high) > n_c) ? n_c : CW'(dst_high);
   end

   // capture item
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         mode_ff <= mode;
         sl_ff <= SW'(sl_c - CW'(1));
         sh_ff <= SW'(sh_c - CW'(1));
         dl_ff <= SW'(dl_c - CW'(1));
         dh_ff <= SW'(dh_c - CW'(1));
      end
   end
   always_ff @(posedge clock) begin
      if (reset) begin
         src_ok_ff <= 1'b0;
         dst_ok_ff <= 1'b0;
      end else if (cmd.load) begin
         src_ok_ff <= (n_c != '0) && (sl_c <= sh_c);
         dst_ok_ff <= (n_c != '0) && (dl_c <= dh_c);
      end
   end

   logic [SW-1:0] lo0, hi0;
   assign lo0 = cmd.dst_pass ? dl_ff : sl_ff;
   assign hi0 = cmd.dst_pass ? dh_ff : sh_ff;

   // word address counter
   always_comb begin
      addr_in = addr_ff;
      if (cmd.first) begin
         addr_in = AW'(lo0 / WordBits);
      end else if (cmd.wr) begin
         addr_in = addr_ff + AW'(1);
      end
   end
   always_ff @(posedge clock) begin
      addr_ff <= addr_in;
      if (cmd.first) begin
         end_ff <= AW'(hi0 / WordBits);
      end
   end
   assign sts.last_word = (addr_ff == end_ff);
   assign sts.src_ok = src_ok_ff;
   assign sts.dst_ok = dst_ok_ff;

   brf_ram #(.WIDTH(WordBits), .DEPTH(NWords)) u_ram (
      .clock(clock), .we(cmd.wr), .waddr(addr_ff), .wdata(wdata),
      .raddr(addr_ff), .rdata(rdata)
   );

   // init tracking per word
   always_ff @(posedge clock) begin
      if (reset) begin
         init_ff <= '0;
      end else if (cmd.wr) begin
         init_ff[addr_ff] <= 1'b1;
      end
   end
   always_ff @(posedge clock) begin
      valid_addr_ff <= addr_ff;
      valid_ff <= init_ff[addr_ff];
   end

   // per-bit processing of the current word
   logic [WordBits-1:0] word;
   logic [SW-1:0] base;
   logic [SW-1:0] pos;
   logic          in_rng;
   always_comb begin
      word = valid_ff ? rdata : '1;
      wdata = word;
      count_in = count_ff;
      run_in = run_ff;
      best_in = best_ff;
      base = SW'({valid_addr_ff, {$clog2(WordBits){1'b0}}});
      for (int b = 0; b < WordBits; b++) begin
         pos = base + SW'(b);
         in_rng = (pos >= lo0) && (pos <= hi0);
         if (in_rng) begin
            if (cmd.dst_pass) begin
               if (!word[b] && count_in != '0) begin
                  wdata[b] = 1'b1;
                  count_in = count_in - SW'(1);
               end
            end else if (mode_ff == ModeQuery) begin
               if (word[b]) begin
                  run_in = '0;
               end else begin
                  run_in = run_in + SW'(1);
                  if (run_in > best_in) best_in = run_in;
               end
            end else begin
               count_in = count_in + SW'(word[b]);
               wdata[b] = 1'b0;
            end
         end
      end
      if (cmd.first && !cmd.dst_pass) begin
         count_in = '0;
      end
      if (cmd.first) begin
         run_in = '0;
         best_in = '0;
      end
   end

   // accumulators clear at pass start and update at write-back
   always_ff @(posedge clock) begin
      if (cmd.first && !cmd.dst_pass) begin
         count_ff <= '0;
         run_ff <= '0;
         best_ff <= '0;
      end else if (cmd.first) begin
         run_ff <= '0;
         best_ff <= '0;
      end else if (cmd.wr) begin
         count_ff <= count_in;
         run_ff <= run_in;
         best_ff <= best_in;
      end
   end
   assign longest_free_run = (src_ok_ff) ? 11'(best_ff) : 11'd0;
endmodule
`default_nettype wire

// ===== hdl/brf_ctrl.sv =====
// file: controller sequencing the word walk passes
`default_nettype none
module brf_ctrl import brf_pkg::*; (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output      logic       req_stall,
   input  wire logic [1:0] req_mode,
   output      logic       rsp_valid,
   input  wire logic       rsp_stall,
   output      logic       busy,
   output      cmd_type    cmd,
   input  wire sts_type    sts
);
   typedef enum logic [5:0] {
      IDLE  = 6'b000001,
      SETUP = 6'b000010,
      READ  = 6'b000100,
      WAIT  = 6'b001000,
      WRITE = 6'b010000,
      DONE  = 6'b100000
   } state_type;

   state_type state_ff, state_in;
   logic [1:0] mode_ff;
   logic dst_ff, dst_in;
   logic rsp_valid_ff, rsp_valid_in;

   assign req_stall = (state_ff != IDLE) || (rsp_valid_ff && rsp_stall);
   assign rsp_valid = rsp_valid_ff;
   assign busy = (state_ff != IDLE);

   // state transitions
   always_comb begin
      state_in = state_ff;
      dst_in = dst_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      cmd = '0;
      cmd.dst_pass = dst_ff;
      case (state_ff)
         IDLE: begin
            if (req_valid && !req_stall) begin
               cmd.load = 1'b1;
               dst_in = 1'b0;
               state_in = (req_mode == ModeNop) ? IDLE : SETUP;
            end
         end
         SETUP: begin
            if ((dst_ff && !sts.dst_ok) || (!dst_ff && !sts.src_ok)) begin
               state_in = DONE;
            end else begin
               cmd.first = 1'b1;
               state_in = READ;
            end
         end
         READ: state_in = WAIT;
         WAIT: state_in = WRITE;
         WRITE: begin
            // queries write the word back unchanged
            cmd.wr = 1'b1;
            if (sts.last_word) begin
               if (mode_ff == ModeMove && !dst_ff) begin
                  dst_in = 1'b1;
                  state_in = SETUP;
               end else begin
                  state_in = DONE;
               end
            end else begin
               state_in = READ;
            end
         end
         DONE: begin
            if (mode_ff == ModeQuery) begin
               rsp_valid_in = 1'b1;
            end
            state_in = IDLE;
         end
         default: state_in = IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= IDLE;
         rsp_valid_ff <= 1'b0;
         dst_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         dst_ff <= dst_in;
      end
   end
   always_ff @(posedge clock) begin
      if (cmd.load) mode_ff <= req_mode;
   end

   // a result only appears as a query finishes
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(state_ff == DONE))
      else $error("result without finished query");
   // no item taken while busy
   assert property (@(posedge clock) disable iff (reset)
      (state_ff != IDLE) |-> req_stall)
      else $error("item accepted while busy");
   // destination pass only for moves
   assert property (@(posedge clock) disable iff (reset)
      dst_ff |-> (mode_ff == ModeMove))
      else $error("destination pass outside move");
endmodule
`default_nettype wire
